FILE: hw/rtl/imoi_pkg.sv
// shared types and codes for the interval map overwrite insert block
package imoi_pkg;

  localparam int TableEntriesDefault = 64;

  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic [2:0] OP_HOLD  = 3'd0;
  localparam logic [2:0] OP_DEL   = 3'd1;
  localparam logic [2:0] OP_SPLIT = 3'd2;
  localparam logic [2:0] OP_TRIM  = 3'd3;
  localparam logic [2:0] OP_INS   = 3'd4;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] off;
    logic [15:0] flg;
    logic [15:0] tag;
    logic        file;
  } entry_t;

  typedef struct packed {
    logic live;
    logic ge_s;
    logic covered;
    logic split;
    logic hit;
  } cell_stat_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] s;
    logic [63:0] e;
    entry_t      ins;
  } cell_cmd_t;

endpackage

FILE: hw/rtl/interval_map_overwrite_insert_core.sv
// top level: range table as a row of cells with the edit sequencer
// An item is taken with start while busy is low; its single result appears with done in the
// first cycle in which busy is low again; results cannot be held off. A lookup compares all
// cells at once. An empty add range is dropped and one that would overflow is rejected with
// status set; else old ranges that the new range covers completely leave the row one per
// cycle as the cells behind move one place down, a step trims or splits ranges it overlaps
// in part, and the new range is placed. The table starts empty; there is no clearing pass.
module interval_map_overwrite_insert_core
  import imoi_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [63:0] map_start,
  input  logic [63:0] map_end,
  input  logic [63:0] map_offset,
  input  logic [15:0] map_flags,
  input  logic        map_is_file,
  input  logic [15:0] map_name_tag,
  input  logic [63:0] lookup_address,
  output logic        done,
  output logic        status,
  output logic        hit,
  output logic [63:0] found_start,
  output logic [63:0] found_end,
  output logic [63:0] found_offset,
  output logic [15:0] found_flags,
  output logic [15:0] found_name_tag,
  output logic        found_is_file
);

  localparam int N  = TABLE_ENTRIES;
  localparam int CW = $clog2(N+1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DEL   = 3'd2;
  localparam logic [2:0] S_TRIM  = 3'd3;
  localparam logic [2:0] S_INS   = 3'd4;
  localparam logic [2:0] S_LOOK  = 3'd5;

  logic [2:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [63:0]   s_reg, e_reg;
  entry_t        ins_reg;
  cell_cmd_t     cmd;

  entry_t     entries [N];
  entry_t     tails   [N];
  cell_stat_t stats   [N];
  logic [N-1:0] hit_vec;

  logic   any_covered, any_split, overflow, finish, fin_status, fin_hit;
  entry_t found;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      entry_t     l_entry, l_tail, r_entry;
      cell_stat_t l_stat;
      if (g == 0) begin : g_first
        assign l_entry = '0;
        assign l_tail  = '0;
        assign l_stat  = '0;
      end else begin : g_mid
        assign l_entry = entries[g-1];
        assign l_tail  = tails[g-1];
        assign l_stat  = stats[g-1];
      end
      if (g == N-1) begin : g_last
        assign r_entry = entries[g];
      end else begin : g_inner
        assign r_entry = entries[g+1];
      end
      imoi_cell #(.N(N), .IDX(g)) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .count      (count),
        .left_entry (l_entry),
        .left_tail  (l_tail),
        .left_stat  (l_stat),
        .right_entry(r_entry),
        .entry      (entries[g]),
        .tail       (tails[g]),
        .stat       (stats[g])
      );
      assign hit_vec[g] = stats[g].hit;
    end
  endgenerate

  always_comb begin
    any_covered = 1'b0;
    any_split   = 1'b0;
    found       = '0;
    for (int i = 0; i < N; i++) begin
      any_covered = any_covered | stats[i].covered;
      any_split   = any_split | stats[i].split;
      if (stats[i].hit) found = found | entries[i];
    end
    if (any_split) begin
      overflow = ({1'b0, count} + (CW+1)'(2)) > (CW+1)'(N);
    end else begin
      overflow = !any_covered && (count == CW'(N));
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd.s   = s_reg;
    cmd.e   = e_reg;
    cmd.ins = ins_reg;
    cmd.op  = OP_HOLD;
    state_next = state;
    count_next = count;
    finish     = 1'b0;
    fin_status = 1'b0;
    fin_hit    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = (kind == KIND_LOOKUP) ? S_LOOK : S_CHECK;
      end
      S_CHECK: begin
        if (s_reg >= e_reg) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end else if (overflow) begin
          finish     = 1'b1;
          fin_status = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_DEL;
        end
      end
      S_DEL: begin
        if (any_covered) begin
          cmd.op     = OP_DEL;
          count_next = count - CW'(1);
        end else begin
          state_next = S_TRIM;
        end
      end
      S_TRIM: begin
        if (any_split) begin
          cmd.op     = OP_SPLIT;
          count_next = count + CW'(1);
        end else begin
          cmd.op = OP_TRIM;
        end
        state_next = S_INS;
      end
      S_INS: begin
        cmd.op     = OP_INS;
        count_next = count + CW'(1);
        finish     = 1'b1;
        state_next = S_IDLE;
      end
      S_LOOK: begin
        finish     = 1'b1;
        fin_hit    = |hit_vec;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      s_reg       <= (kind == KIND_LOOKUP) ? lookup_address : map_start;
      e_reg       <= map_end;
      ins_reg.lo  <= map_start;
      ins_reg.hi  <= map_end;
      ins_reg.off <= map_offset;
      ins_reg.flg <= map_flags;
      ins_reg.tag <= map_name_tag;
      ins_reg.file <= map_is_file;
    end
    if (finish) begin
      status         <= fin_status;
      hit            <= fin_hit;
      found_start    <= fin_hit ? found.lo : 64'd0;
      found_end      <= fin_hit ? found.hi : 64'd0;
      found_offset   <= fin_hit ? found.off : 64'd0;
      found_flags    <= fin_hit ? found.flg : 16'd0;
      found_name_tag <= fin_hit ? found.tag : 16'd0;
      found_is_file  <= fin_hit ? found.file : 1'b0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(N)) else $error("range count above table size");

  a_one_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_vec)) else $error("address found in more than one range");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) != S_IDLE) else $error("result without a transaction");

  a_status_hit: assert property (@(posedge clk) disable iff (rst)
    done |-> !(status && hit)) else $error("rejected add reported a hit");

  a_reject_keeps: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && overflow && s_reg < e_reg) |=> $stable(count))
    else $error("rejected add changed the table");

endmodule

FILE: hw/rtl/imoi_cell.sv
// one table slot: holds a range and edits it from its neighbors
module imoi_cell
  import imoi_pkg::*;
#(
  parameter int N   = TableEntriesDefault,
  parameter int IDX = 0
) (
  input  logic                       clk,
  input  cell_cmd_t                  cmd,
  input  logic [$clog2(N+1)-1:0]     count,
  input  entry_t                     left_entry,
  input  entry_t                     left_tail,
  input  cell_stat_t                 left_stat,
  input  entry_t                     right_entry,
  output entry_t                     entry,
  output entry_t                     tail,
  output cell_stat_t                 stat
);

  localparam int CW = $clog2(N+1);
  localparam logic [CW-1:0] IdxC = CW'(IDX);

  entry_t entry_next;
  logic   live, ge_s, lt_e, b_gt_s, b_gt_e, b_le_e, a_le_s;
  logic   head_cut, tail_cut, slot;

  always_comb begin
    live     = IdxC < count;
    ge_s     = entry.lo >= cmd.s;
    a_le_s   = entry.lo <= cmd.s;
    lt_e     = entry.lo < cmd.e;
    b_gt_s   = entry.hi > cmd.s;
    b_gt_e   = entry.hi > cmd.e;
    b_le_e   = entry.hi <= cmd.e;
    head_cut = live && !ge_s && b_gt_s;
    tail_cut = live && ge_s && lt_e && b_gt_e;

    stat.live    = live;
    stat.ge_s    = live && ge_s;
    stat.covered = live && ge_s && b_le_e;
    stat.split   = live && !ge_s && b_gt_e;
    stat.hit     = live && a_le_s && b_gt_s;

    tail     = entry;
    tail.lo  = cmd.e;
    tail.off = entry.file ? (entry.off + (cmd.e - entry.lo)) : 64'd0;

    slot = ((IDX == 0) || (left_stat.live && !left_stat.ge_s)) && (!live || ge_s);

    entry_next = entry;
    case (cmd.op)
      OP_DEL: begin
        if (live && ge_s) entry_next = right_entry;
      end
      OP_SPLIT: begin
        if (live && !ge_s && b_gt_e) begin
          entry_next.hi = cmd.s;
        end else if (left_stat.split) begin
          entry_next = left_tail;
        end else if (left_stat.ge_s) begin
          entry_next = left_entry;
        end
      end
      OP_TRIM: begin
        if (head_cut) begin
          entry_next.hi = cmd.s;
        end else if (tail_cut) begin
          entry_next = tail;
        end
      end
      OP_INS: begin
        if (slot) begin
          entry_next = cmd.ins;
        end else if (left_stat.ge_s) begin
          entry_next = left_entry;
        end
      end
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
